### rtl/sorted_key_table_unit_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef SORTED_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SKT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SKT_NEVER(lbl, expr, msg) \
	`SKT_ASSERT(lbl, !(expr), msg)
`else
`define SKT_ASSERT(lbl, prop, msg)
`define SKT_NEVER(lbl, expr, msg)
`endif

`endif

### rtl/skt_pkg.sv
package skt_pkg;

	localparam int unsigned DEPTH_DEF = 64;

	localparam int unsigned ACT_W    = 2;
	localparam int unsigned KEY_W    = 31;
	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned ENTRY_W  = KEY_W + HANDLE_W;
	localparam int unsigned IN_W     = ((KEY_W + HANDLE_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_UP,
		S_INS_WR,
		S_SHIFT_DN,
		S_RESP
	} state_t;

endpackage

### rtl/skt_ram.sv
module skt_ram #(
	parameter int unsigned WIDTH = skt_pkg::ENTRY_W,
	parameter int unsigned DEPTH = skt_pkg::DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/sorted_key_table_unit.sv
// Operation: a scan reads entries from slot 0 up to the first key not above the search key
// or past the last entry; a stored insert then shifts entries up from the insert point and
// writes the new one, a delete shifts later entries down; an unused action skips the scan.
// Throughput: one operation at a time, one entry read or moved per cycle; the next item is
// taken while the previous result waits in the output register.
// Reset: control and entry count clear at once; the table is empty and RAM needs no clearing.
`include "sorted_key_table_unit_macros.svh"

module sorted_key_table_unit #(
	parameter int unsigned DEPTH = skt_pkg::DEPTH_DEF,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1),
	localparam int unsigned OUT_W = ((skt_pkg::HANDLE_W + CNT_W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [skt_pkg::IN_W-1:0]   s_axis_tdata,  // account_key, record_handle, zero pad
	input  logic [skt_pkg::ACT_W-1:0]  s_axis_tuser,  // action
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [OUT_W-1:0]           m_axis_tdata,  // found_handle, entry_count, zero pad
	output logic [skt_pkg::STAT_W-1:0] m_axis_tuser   // status
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned KW = skt_pkg::KEY_W;
	localparam int unsigned HW = skt_pkg::HANDLE_W;
	localparam int unsigned EW = skt_pkg::ENTRY_W;

	skt_pkg::state_t state_q, state_d;

	logic [skt_pkg::ACT_W-1:0]  act_q, act_d;
	logic [KW-1:0]              key_q, key_d;
	logic [HW-1:0]              hdl_q, hdl_d;
	logic [CNT_W-1:0]           cnt_q, cnt_d;
	logic [CNT_W-1:0]           idx_q, idx_d;
	logic [CNT_W-1:0]           pos_q, pos_d;
	logic                       pend_s1, pend_d;
	logic [AW-1:0]              dst_s1, dst_d;
	logic [skt_pkg::STAT_W-1:0] res_st_q, res_st_d;
	logic [HW-1:0]              res_hdl_q, res_hdl_d;

	logic                       out_vld_q, out_vld_d;
	logic                       out_load;
	logic [skt_pkg::STAT_W-1:0] out_st_q;
	logic [HW-1:0]              out_hdl_q;
	logic [CNT_W-1:0]           out_cnt_q;

	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [EW-1:0] ram_wr_data;
	logic [AW-1:0] ram_rd_addr;
	logic [EW-1:0] ram_rd_data;

	logic [KW-1:0]    rd_key;
	logic [HW-1:0]    rd_hdl;
	logic             scan_hit;
	logic             scan_end;
	logic             f_eq;
	logic [CNT_W-1:0] f_pos;
	logic             in_beat;

	assign rd_key = ram_rd_data[EW-1:HW];
	assign rd_hdl = ram_rd_data[HW-1:0];

	assign in_beat = s_axis_tvalid && s_axis_tready;

	// stop at the first entry whose key is not above the search key, or past the last entry
	assign scan_hit = (state_q == skt_pkg::S_SCAN) && pend_s1 && !(rd_key > key_q);
	assign scan_end = (state_q == skt_pkg::S_SCAN) && !pend_s1 && (idx_q == cnt_q);
	assign f_eq     = scan_hit && (rd_key == key_q);
	assign f_pos    = scan_hit ? CNT_W'(dst_s1) : cnt_q;

	always_comb begin
		state_d     = state_q;
		act_d       = act_q;
		key_d       = key_q;
		hdl_d       = hdl_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		pos_d       = pos_q;
		pend_d      = 1'b0;
		dst_d       = dst_s1;
		res_st_d    = res_st_q;
		res_hdl_d   = res_hdl_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = dst_s1;
		ram_wr_data = ram_rd_data;
		ram_rd_addr = idx_q[AW-1:0];
		out_load    = 1'b0;

		case (state_q)
			skt_pkg::S_IDLE: begin
				if (in_beat) begin
					act_d     = s_axis_tuser;
					key_d     = s_axis_tdata[KW-1:0];
					hdl_d     = s_axis_tdata[KW+HW-1:KW];
					idx_d     = '0;
					res_st_d  = skt_pkg::STAT_OK;
					res_hdl_d = '0;
					if (s_axis_tuser == skt_pkg::ACT_INSERT || s_axis_tuser == skt_pkg::ACT_FIND
						|| s_axis_tuser == skt_pkg::ACT_DELETE) begin
						state_d = skt_pkg::S_SCAN;
					end else begin
						state_d = skt_pkg::S_RESP;
					end
				end
			end
			skt_pkg::S_SCAN: begin
				if (scan_hit || scan_end) begin
					pos_d = f_pos;
					case (act_q)
						skt_pkg::ACT_FIND: begin
							res_st_d  = f_eq ? skt_pkg::STAT_OK : skt_pkg::STAT_NOTFOUND;
							res_hdl_d = f_eq ? rd_hdl : '0;
							state_d   = skt_pkg::S_RESP;
						end
						skt_pkg::ACT_INSERT: begin
							if (f_eq) begin
								res_st_d = skt_pkg::STAT_DUP;
								state_d  = skt_pkg::S_RESP;
							end else if (cnt_q == CNT_W'(DEPTH)) begin
								res_st_d = skt_pkg::STAT_FULL;
								state_d  = skt_pkg::S_RESP;
							end else begin
								idx_d   = cnt_q;
								state_d = skt_pkg::S_SHIFT_UP;
							end
						end
						skt_pkg::ACT_DELETE: begin
							if (f_eq) begin
								idx_d   = f_pos + CNT_W'(1);
								state_d = skt_pkg::S_SHIFT_DN;
							end else begin
								res_st_d = skt_pkg::STAT_NOTFOUND;
								state_d  = skt_pkg::S_RESP;
							end
						end
						default: begin
							state_d = skt_pkg::S_RESP;
						end
					endcase
				end else if (idx_q != cnt_q) begin
					pend_d = 1'b1;
					dst_d  = idx_q[AW-1:0];
					idx_d  = idx_q + CNT_W'(1);
				end
			end
			skt_pkg::S_SHIFT_UP: begin
				// move entry idx-1 up to idx, walking down toward the insert point
				ram_wr_en = pend_s1;
				if (idx_q != pos_q) begin
					ram_rd_addr = AW'(idx_q - CNT_W'(1));
					pend_d      = 1'b1;
					dst_d       = idx_q[AW-1:0];
					idx_d       = idx_q - CNT_W'(1);
				end else if (!pend_s1) begin
					state_d = skt_pkg::S_INS_WR;
				end
			end
			skt_pkg::S_INS_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = pos_q[AW-1:0];
				ram_wr_data = {key_q, hdl_q};
				cnt_d       = cnt_q + CNT_W'(1);
				state_d     = skt_pkg::S_RESP;
			end
			skt_pkg::S_SHIFT_DN: begin
				// move entry idx down to idx-1, closing the gap
				ram_wr_en = pend_s1;
				if (idx_q < cnt_q) begin
					pend_d = 1'b1;
					dst_d  = AW'(idx_q - CNT_W'(1));
					idx_d  = idx_q + CNT_W'(1);
				end else if (!pend_s1) begin
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = skt_pkg::S_RESP;
				end
			end
			skt_pkg::S_RESP: begin
				if (!out_vld_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = skt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_vld_d = out_vld_q;
		if (out_load) begin
			out_vld_d = 1'b1;
		end else if (m_axis_tready) begin
			out_vld_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= skt_pkg::S_IDLE;
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			pend_s1   <= pend_d;
			out_vld_q <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q     <= act_d;
		key_q     <= key_d;
		hdl_q     <= hdl_d;
		idx_q     <= idx_d;
		pos_q     <= pos_d;
		dst_s1    <= dst_d;
		res_st_q  <= res_st_d;
		res_hdl_q <= res_hdl_d;
		if (out_load) begin
			out_st_q  <= res_st_q;
			out_hdl_q <= res_hdl_q;
			out_cnt_q <= cnt_q;
		end
	end

	skt_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign s_axis_tready = (state_q == skt_pkg::S_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_st_q;
	assign m_axis_tdata  = OUT_W'({out_cnt_q, out_hdl_q});

	`SKT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
	`SKT_ASSERT(a_cnt_step, !$stable(cnt_q) |->
		(cnt_q == $past(cnt_q) + CNT_W'(1) || cnt_q == $past(cnt_q) - CNT_W'(1)),
		"entry count jumped")
	`SKT_ASSERT(a_wr_state, ram_wr_en |-> (state_q == skt_pkg::S_SHIFT_UP
		|| state_q == skt_pkg::S_INS_WR || state_q == skt_pkg::S_SHIFT_DN),
		"RAM write outside shift")
	`SKT_NEVER(a_ins_pend, state_q == skt_pkg::S_INS_WR && pend_s1, "shift write lost at insert")
	`SKT_ASSERT(a_full_cnt, (m_axis_tvalid && m_axis_tuser == skt_pkg::STAT_FULL)
		|-> out_cnt_q == CNT_W'(DEPTH), "full status below depth")

endmodule
